// ===== hdl/ksm_pkg.sv =====
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared constants, codes and types of the streaming KMP matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ksm_pkg;

  localparam int MaxPattern = 64;
  localparam int AddrW      = $clog2(MaxPattern);
  localparam int CountW     = $clog2(MaxPattern + 1);
  localparam int PosBits    = 32;
  localparam int MatchPosW  = 32;
  localparam int ByteW      = 8;
  localparam int CmdW       = 2;
  localparam int StatusW    = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_TEXT   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 3'd0,
    STAT_MATCH   = 3'd1,
    STAT_EARLIER = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_NOPAT   = 3'd4,
    STAT_CLEARED = 3'd5
  } status_e;

  // text position bookkeeping: saturated next position and match start
  typedef struct packed {
    logic [PosBits-1:0] next;
    logic [PosBits-1:0] start;
  } pos_res_t;

endpackage

`default_nettype wire

// ===== hdl/ksm_if.sv =====
// ----------------------------------------------------------------------------
// ksm_if
// Valid/ready channels of the matcher: command words in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ksm_in_if;
  logic                        valid;
  logic                        ready;
  logic [ksm_pkg::CmdW-1:0]    command;
  logic [ksm_pkg::ByteW-1:0]   byte_value;

  modport source (output valid, output command, output byte_value, input ready);
  modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface ksm_out_if;
  logic                          valid;
  logic                          ready;
  logic [ksm_pkg::StatusW-1:0]   status;
  logic [ksm_pkg::MatchPosW-1:0] match_position;
  logic [ksm_pkg::CountW-1:0]    loaded_length;

  modport source (output valid, output status, output match_position,
                  output loaded_length, input ready);
  modport sink   (input valid, input status, input match_position,
                  input loaded_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/kmp_stream_matcher.sv =====
// Flow: an accepted command word is registered together with its pattern and
// failure memory read; each failure-table fallback step reads them again.
// A new command word is not taken until the run ends and its result word is
// registered; fallback steps per word are at most the loaded length minus one.
// Reset: control, counters and position clear asynchronously; pattern and
// failure memories are not cleared, only entries below the loaded count are read.
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// Streaming Knuth-Morris-Pratt matcher with incremental failure-table build.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_stream_matcher (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ksm_in_if.sink          cmd_i,
  ksm_out_if.source       rsp_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  localparam logic [ksm_pkg::CountW-1:0] CountMax = ksm_pkg::CountW'(ksm_pkg::MaxPattern);

  logic                           state_q, state_d;
  logic [ksm_pkg::CmdW-1:0]       cmd_q, cmd_d;
  logic [ksm_pkg::ByteW-1:0]      byte_q, byte_d;
  logic [ksm_pkg::AddrW-1:0]      j_q, j_d;
  logic [ksm_pkg::CountW-1:0]     count_q, count_d;
  logic [ksm_pkg::AddrW-1:0]      bpl_q, bpl_d;
  logic [ksm_pkg::CountW-1:0]     mp_q, mp_d;
  logic [ksm_pkg::PosBits-1:0]    tp_q, tp_d;
  logic                           found_q, found_d;
  logic [ksm_pkg::PosBits-1:0]    fpos_q, fpos_d;
  logic                           out_valid_q, out_valid_d;
  logic [ksm_pkg::StatusW-1:0]    out_status_q, out_status_d;
  logic [ksm_pkg::MatchPosW-1:0]  out_pos_q, out_pos_d;
  logic [ksm_pkg::CountW-1:0]     out_len_q, out_len_d;

  logic                           accept;
  logic [ksm_pkg::AddrW-1:0]      j0;
  logic [ksm_pkg::AddrW-1:0]      rd_j;
  logic [ksm_pkg::ByteW-1:0]      p_rdata;
  logic [ksm_pkg::AddrW-1:0]      f_rdata;
  logic                           hit;
  logic                           searching;
  logic                           step;
  logic                           out_free;
  logic                           finish;
  logic [ksm_pkg::CountW-1:0]     jf;
  logic                           mem_we;
  logic [ksm_pkg::AddrW-1:0]      f_wdata;
  ksm_pkg::pos_res_t              pos_res;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;

  // starting prefix length for the fallback walk
  always_comb begin
    if (cmd_i.command == ksm_pkg::CMD_APPEND) begin
      j0 = bpl_q;
    end else if (mp_q >= count_q) begin
      j0 = '0;
    end else begin
      j0 = mp_q[ksm_pkg::AddrW-1:0];
    end
  end

  assign hit = (p_rdata == byte_q);

  assign searching =
      ((cmd_q == ksm_pkg::CMD_APPEND) && (count_q != '0) && (count_q != CountMax)) ||
      ((cmd_q == ksm_pkg::CMD_TEXT) && (count_q != '0) && !found_q);

  assign step     = (state_q == S_RUN) && searching && (j_q != '0) && !hit;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign finish   = (state_q == S_RUN) && !step && out_free;
  assign jf       = ksm_pkg::CountW'(j_q) + ksm_pkg::CountW'(hit);

  // hold the address while stalled so the read data stays put
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_j = j0;
    end else if (step) begin
      rd_j = f_rdata;
    end else begin
      rd_j = j_q;
    end
  end

  ksm_ram #(
    .Width (ksm_pkg::ByteW),
    .Depth (ksm_pkg::MaxPattern)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[ksm_pkg::AddrW-1:0]),
    .wdata_i (byte_q),
    .raddr_i (rd_j),
    .rdata_o (p_rdata)
  );

  ksm_ram #(
    .Width (ksm_pkg::AddrW),
    .Depth (ksm_pkg::MaxPattern)
  ) u_failure_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[ksm_pkg::AddrW-1:0]),
    .wdata_i (f_wdata),
    .raddr_i (rd_j - ksm_pkg::AddrW'(1)),
    .rdata_o (f_rdata)
  );

  ksm_pos u_pos (
    .pos_i   (tp_q),
    .count_i (count_q),
    .res_o   (pos_res)
  );

  assign mem_we  = finish && (cmd_q == ksm_pkg::CMD_APPEND) && (count_q != CountMax);
  assign f_wdata = (count_q == '0) ? '0 : jf[ksm_pkg::AddrW-1:0];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    byte_d       = byte_q;
    j_d          = j_q;
    count_d      = count_q;
    bpl_d        = bpl_q;
    mp_d         = mp_q;
    tp_d         = tp_q;
    found_d      = found_q;
    fpos_d       = fpos_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_len_d    = out_len_q;

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      state_d = S_RUN;
      cmd_d   = cmd_i.command;
      byte_d  = cmd_i.byte_value;
      j_d     = j0;
    end

    if (step) begin
      j_d = f_rdata;
    end

    if (finish) begin
      state_d      = S_IDLE;
      out_valid_d  = 1'b1;
      out_status_d = ksm_pkg::STAT_OK;
      out_pos_d    = '0;
      case (cmd_q)
        ksm_pkg::CMD_APPEND: begin
          if (count_q == CountMax) begin
            out_status_d = ksm_pkg::STAT_FULL;
          end else begin
            bpl_d   = f_wdata;
            count_d = count_q + ksm_pkg::CountW'(1);
          end
        end
        ksm_pkg::CMD_TEXT: begin
          if (count_q == '0) begin
            out_status_d = ksm_pkg::STAT_NOPAT;
          end else if (found_q) begin
            tp_d         = pos_res.next;
            out_status_d = ksm_pkg::STAT_EARLIER;
            out_pos_d    = ksm_pkg::MatchPosW'(fpos_q);
          end else begin
            mp_d = jf;
            tp_d = pos_res.next;
            if (jf == count_q) begin
              found_d      = 1'b1;
              fpos_d       = pos_res.start;
              out_status_d = ksm_pkg::STAT_MATCH;
              out_pos_d    = ksm_pkg::MatchPosW'(pos_res.start);
            end
          end
        end
        ksm_pkg::CMD_CLEAR: begin
          count_d      = '0;
          bpl_d        = '0;
          mp_d         = '0;
          tp_d         = '0;
          found_d      = 1'b0;
          fpos_d       = '0;
          out_status_d = ksm_pkg::STAT_CLEARED;
        end
        default: begin
          out_status_d = ksm_pkg::STAT_OK;
        end
      endcase
      out_len_d = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      bpl_q       <= '0;
      mp_q        <= '0;
      tp_q        <= '0;
      found_q     <= 1'b0;
      fpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bpl_q       <= bpl_d;
      mp_q        <= mp_d;
      tp_q        <= tp_d;
      found_q     <= found_d;
      fpos_q      <= fpos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    byte_q       <= byte_d;
    j_q          <= j_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_len_q    <= out_len_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.match_position = out_pos_q;
  assign rsp_o.loaded_length  = out_len_q;

`ifndef SYNTH
  // running prefix length is a proper prefix of the loaded pattern
  a_bpl_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (ksm_pkg::CountW'(bpl_q) < count_q))
    else $error("build prefix length not below pattern count");

  a_progress_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mp_q <= count_q)
    else $error("match progress beyond pattern count");

  a_found_needs_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (count_q != '0))
    else $error("match latched with empty pattern");

  // a result only appears at the end of a run
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RUN))
    else $error("result word raised outside a run");
`endif

endmodule

`default_nettype wire

// ===== hdl/ksm_ram.sv =====
// ----------------------------------------------------------------------------
// ksm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/ksm_pos.sv =====
// ----------------------------------------------------------------------------
// ksm_pos
// Text position unit: saturating increment and start index of a match.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_pos (
  input  wire logic [ksm_pkg::PosBits-1:0] pos_i,
  input  wire logic [ksm_pkg::CountW-1:0]  count_i,
  output      ksm_pkg::pos_res_t           res_o
);

  localparam logic [ksm_pkg::PosBits-1:0] PosMax = '1;

  logic [ksm_pkg::PosBits:0] pos_inc;
  logic [ksm_pkg::PosBits:0] count_ext;
  logic [ksm_pkg::PosBits:0] diff;

  assign pos_inc   = {1'b0, pos_i} + (ksm_pkg::PosBits + 1)'(1);
  assign count_ext = (ksm_pkg::PosBits + 1)'(count_i);
  assign diff      = pos_inc - count_ext;

  assign res_o.next  = (pos_i == PosMax) ? pos_i : pos_inc[ksm_pkg::PosBits-1:0];
  // start below zero clamps to zero
  assign res_o.start = (pos_inc >= count_ext) ? diff[ksm_pkg::PosBits-1:0] : '0;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming KMP matcher. Pattern, text, clear and
// unused command words go in through the valid/ready input channel. A scoreboard
// keeps its own matcher state (pattern, failure table, progress, position),
// predicts the result word of every accepted command word and checks the words
// coming out in order. Both channels idle at random, and the result side holds
// off once for a long time so that backpressure reaches the input.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ksm_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int              WordGoal  = 1100;
  localparam int              HoldLen   = 300;

  class match_scoreboard;
    typedef struct packed {
      logic [StatusW-1:0]   status;
      logic [MatchPosW-1:0] pos;
      logic [CountW-1:0]    len;
    } result_t;

    localparam longint unsigned PosMax = (64'd1 << PosBits) - 1;

    logic [ByteW-1:0]  pat_mem  [MaxPattern];
    logic [CountW-1:0] fail_mem [MaxPattern];
    int unsigned       pat_len;
    int unsigned       build_len;
    int unsigned       progress;
    longint unsigned   text_pos;
    longint unsigned   found_pos;
    bit                found;
    result_t           expected_q[$];
    int                errors;

    function new();
      pat_len   = 0;
      build_len = 0;
      progress  = 0;
      text_pos  = 0;
      found_pos = 0;
      found     = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void step_position();
      if (text_pos < PosMax) text_pos++;
    endfunction

    // work out the result of one accepted command word and queue it
    function void note_word(logic [CmdW-1:0] cmd, logic [ByteW-1:0] val);
      result_t     r;
      int unsigned j;
      r.status = STAT_OK;
      r.pos    = '0;
      case (cmd)
        CMD_APPEND: begin
          if (pat_len >= MaxPattern) begin
            r.status = STAT_FULL;
          end else begin
            pat_mem[pat_len] = val;
            if (pat_len == 0) begin
              fail_mem[0] = '0;
              build_len   = 0;
            end else begin
              j = build_len;
              while (j > 0 && pat_mem[j] != val) j = fail_mem[j-1];
              if (pat_mem[j] == val) j++;
              fail_mem[pat_len] = CountW'(j);
              build_len         = j;
            end
            pat_len++;
          end
        end
        CMD_TEXT: begin
          if (pat_len == 0) begin
            r.status = STAT_NOPAT;
          end else if (found) begin
            // match already latched: only the position moves
            step_position();
            r.status = STAT_EARLIER;
            r.pos    = MatchPosW'(found_pos);
          end else begin
            j = progress;
            if (j >= pat_len) j = 0;
            while (j > 0 && pat_mem[j] != val) j = fail_mem[j-1];
            if (pat_mem[j] == val) j++;
            progress = j;
            if (j == pat_len) begin
              found     = 1'b1;
              found_pos = (text_pos + 1 >= pat_len) ? text_pos + 1 - pat_len : 0;
              r.status  = STAT_MATCH;
              r.pos     = MatchPosW'(found_pos);
            end
            step_position();
          end
        end
        CMD_CLEAR: begin
          pat_len   = 0;
          build_len = 0;
          progress  = 0;
          text_pos  = 0;
          found     = 1'b0;
          found_pos = 0;
          r.status  = STAT_CLEARED;
        end
        default: ;
      endcase
      r.len = CountW'(pat_len);
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(logic [StatusW-1:0] st, logic [MatchPosW-1:0] pos,
                      logic [CountW-1:0] len);
      result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word status %0d with nothing expected", st));
      end else begin
        e = expected_q.pop_front();
        if (st !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
        if (pos !== e.pos)
          report_mismatch($sformatf("match_position %0d, expected %0d", pos, e.pos));
        if (len !== e.len)
          report_mismatch($sformatf("loaded_length %0d, expected %0d", len, e.len));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ksm_in_if  cmd_if ();
  ksm_out_if rsp_if ();

  kmp_stream_matcher uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  match_scoreboard sb = new();

  bit src_idle_on   = 1'b1;
  bit sink_stall_on = 1'b1;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int words_sent    = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one command word and wait until it is taken
  task automatic send_word(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] val);
    while (src_idle_on && $urandom_range(0, 99) < 28) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.byte_value <= val;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sb.note_word(cmd, val);
    if (cmd != CmdUnused) words_sent++;
  endtask

  // optionally clear, load a pattern over a small alphabet, then search text built mostly from it
  task automatic run_search(input bit force_long);
    logic [ByteW-1:0] alpha [3];
    logic [ByteW-1:0] pat[$];
    logic [ByteW-1:0] pick;
    int               plen;
    bit               long_pat;
    for (int k = 0; k < 3; k++) alpha[k] = ByteW'($urandom_range(0, 255));
    long_pat = force_long || ($urandom_range(0, 11) == 0);
    plen     = long_pat ? $urandom_range(58, 68) : $urandom_range(1, 6);
    if (long_pat || $urandom_range(0, 3) != 0)
      send_word(CMD_CLEAR, ByteW'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) == 0) send_word(CMD_TEXT, alpha[2]);
    for (int k = 0; k < plen; k++) begin
      pick = alpha[$urandom_range(0, 1)];
      send_word(CMD_APPEND, pick);
      if (pat.size() < MaxPattern) pat.push_back(pick);
    end
    if (long_pat) begin
      repeat ($urandom_range(0, 8)) send_word(CMD_TEXT, alpha[$urandom_range(0, 1)]);
      foreach (pat[k]) send_word(CMD_TEXT, pat[k]);
      repeat ($urandom_range(1, 4)) send_word(CMD_TEXT, alpha[$urandom_range(0, 2)]);
    end else begin
      repeat ($urandom_range(6, 24)) begin
        case ($urandom_range(0, 29))
          0:       send_word(CMD_APPEND, alpha[$urandom_range(0, 1)]);
          1:       send_word(CmdUnused, ByteW'($urandom_range(0, 255)));
          2, 3:    send_word(CMD_TEXT, ByteW'($urandom_range(0, 255)));
          default: send_word(CMD_TEXT, alpha[$urandom_range(0, 2)]);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int  drain_cycles;
    bit  first;
    bit  hold_done;
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= CMD_APPEND;
    cmd_if.byte_value <= '0;
    rst_ni            <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: no pattern, unused command, byte extremes, fallbacks, match,
    // earlier match with an append behind it, clear, append during a search
    send_word(CMD_TEXT, 8'h41);
    send_word(CmdUnused, 8'hFF);
    send_word(CMD_APPEND, 8'h00);
    send_word(CMD_APPEND, 8'hFF);
    send_word(CMD_APPEND, 8'h00);
    send_word(CMD_TEXT, 8'h00);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_TEXT, 8'h00);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_TEXT, 8'h00);
    send_word(CMD_TEXT, 8'h55);
    send_word(CMD_APPEND, 8'h80);
    send_word(CMD_TEXT, 8'h80);
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_TEXT, 8'hAA);
    send_word(CMD_APPEND, 8'hAA);
    send_word(CMD_APPEND, 8'hAA);
    send_word(CMD_TEXT, 8'hAA);
    send_word(CMD_TEXT, 8'h55);
    send_word(CMD_TEXT, 8'hAA);
    send_word(CMD_APPEND, 8'hAA);
    send_word(CMD_TEXT, 8'hAA);
    send_word(CMD_TEXT, 8'hAA);
    send_word(CMD_CLEAR, 8'hFF);

    first     = 1'b1;
    hold_done = 1'b0;
    while (words_sent < WordGoal) begin
      // quiet stretch in the middle with no idling on either side
      sink_stall_on = !(words_sent >= 300 && words_sent < 550);
      if (!hold_done && words_sent >= 650) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      src_idle_on = sink_stall_on && !hold_req && hold_left == 0;
      if (!first && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(3, 10))
          send_word(CmdW'($urandom_range(0, 3)), ByteW'($urandom_range(0, 255)));
      end else begin
        run_search(first);
      end
      first = 1'b0;
    end
    cmd_if.valid <= 1'b0;

    drain_cycles = 0;
    while (sb.pending() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (100) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d result words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: check each accepted word, then pick the next ready
  initial begin : result_sink
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        sb.check_result(rsp_if.status, rsp_if.match_position, rsp_if.loaded_length);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !(sink_stall_on && $urandom_range(0, 99) < 28);
      end
    end
  end

endmodule

// ===== filelist.f =====
hdl/ksm_pkg.sv
hdl/ksm_if.sv
hdl/ksm_ram.sv
hdl/ksm_pos.sv
hdl/kmp_stream_matcher.sv
tb/testbench.sv
